FILE: rtl/assert_macros.svh
// Assertion helpers for the RTL files; the top-level unit includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define LHF_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
		else $error("lhf assertion failed");

// Consequence must hold in the cycle after the antecedent.
`define LHF_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("lhf assertion failed");

`endif

FILE: rtl/lhf_pkg.sv
package lhf_pkg;

	localparam int OPCODE_BITS          = 2;
	localparam int FAULT_BITS           = 4;
	localparam int CONFIRM_FRAMES_BITS  = 16;
	localparam int CONFIRM_DUR_BITS     = 32;
	localparam int CFG_DATA_BITS        = 32;
	localparam int CFG_INDEX_BITS       = 1;

	localparam logic [CONFIRM_FRAMES_BITS-1:0] CONFIRM_FRAMES_RESET = 16'd3;
	localparam logic [CONFIRM_FRAMES_BITS-1:0] CONFIRM_FRAMES_MIN   = 16'd2;
	localparam logic [CONFIRM_DUR_BITS-1:0]    CONFIRM_DUR_RESET    = 32'd0;
	localparam logic [CONFIRM_DUR_BITS-1:0]    SLACK_US             = 32'd100;
	localparam logic [31:0]                    ROLLBACK_US          = 32'd500000;

	typedef enum logic [OPCODE_BITS-1:0] {
		OP_EVIDENCE      = 2'd0,
		OP_FAIL_CLOSE    = 2'd1,
		OP_SEGMENT_RESET = 2'd2
	} opcode_t;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_CONFIRM_FRAMES   = 1'd0,
		REG_CONFIRM_DURATION = 1'd1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_ACTIVE         = 2'd0,
		ST_PAUSED_QUALITY = 2'd1,
		ST_PAUSED_IO      = 2'd2,
		ST_FAIL_CLOSED    = 2'd3
	} auth_state_t;

	typedef enum logic [3:0] {
		RSN_NONE        = 4'd0,
		RSN_HEALTHY     = 4'd1,
		RSN_IO_NOT_READY = 4'd2,
		RSN_HIGH_FITNESS = 4'd3,
		RSN_TRANSIENT   = 4'd4,
		RSN_NONFINITE   = 4'd5,
		RSN_ROLLBACK    = 4'd6,
		RSN_PHYSICAL    = 4'd7,
		RSN_IDENTITY    = 4'd8,
		RSN_CONFIRMED   = 4'd9,
		RSN_EXPLICIT    = 4'd10
	} reason_t;

	// Authority decision as held between items and reported with each result.
	typedef struct packed {
		auth_state_t state;
		reason_t     reason;
		logic        writes;
		logic        warning;
		logic        latched;
		logic        changed;
	} decision_t;

	localparam decision_t DECISION_RESET = '{
		state:   ST_ACTIVE,
		reason:  RSN_NONE,
		writes:  1'b0,
		warning: 1'b0,
		latched: 1'b0,
		changed: 1'b0
	};

endpackage

FILE: rtl/lhf_if.sv
interface lhf_in_if import lhf_pkg::*; #(
	parameter int STAMP_BITS = 48
);
	logic                    valid;
	logic                    ready;
	logic [OPCODE_BITS-1:0]  opcode;
	logic [STAMP_BITS-1:0]   stamp_us;
	logic                    stamp_finite;
	logic [FAULT_BITS-1:0]   fault_flags;
	logic                    innovation_reject;
	logic                    geometry_bad;
	logic                    observability_bad;
	logic                    match_converged;
	logic                    fitness_high;
	logic                    storage_paused;

	modport source (
		output valid, opcode, stamp_us, stamp_finite, fault_flags, innovation_reject,
		output geometry_bad, observability_bad, match_converged, fitness_high,
		output storage_paused,
		input  ready
	);
	modport sink (
		input  valid, opcode, stamp_us, stamp_finite, fault_flags, innovation_reject,
		input  geometry_bad, observability_bad, match_converged, fitness_high,
		input  storage_paused,
		output ready
	);
endinterface

interface lhf_out_if #(
	parameter int STAMP_BITS = 48,
	parameter int COUNT_BITS = 16
);
	logic                  valid;
	logic                  ready;
	logic [1:0]            authority_state;
	logic [3:0]            reason_code;
	logic                  writes_allowed;
	logic                  warning_allowed;
	logic                  latched;
	logic                  state_changed;
	logic [COUNT_BITS-1:0] failure_count;
	logic [STAMP_BITS-1:0] failure_duration_us;

	modport source (
		output valid, authority_state, reason_code, writes_allowed, warning_allowed,
		output latched, state_changed, failure_count, failure_duration_us,
		input  ready
	);
	modport sink (
		input  valid, authority_state, reason_code, writes_allowed, warning_allowed,
		input  latched, state_changed, failure_count, failure_duration_us,
		output ready
	);
endinterface

FILE: rtl/lhf_cfg_regs.sv
module lhf_cfg_regs import lhf_pkg::*; (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [CFG_INDEX_BITS-1:0]      cfg_index,
	input  logic [CFG_DATA_BITS-1:0]       cfg_wdata,
	output logic [CONFIRM_FRAMES_BITS-1:0] confirm_frames,
	output logic [CONFIRM_DUR_BITS-1:0]    confirm_duration_us,
	output logic                           segment_clear
);
	logic [CONFIRM_FRAMES_BITS-1:0] frames_q;
	logic [CONFIRM_DUR_BITS-1:0]    duration_q;
	logic [CONFIRM_FRAMES_BITS-1:0] frames_wdata;

	// Fewer than two frames cannot confirm a run, so such values are raised to two.
	assign frames_wdata = (cfg_wdata[CONFIRM_FRAMES_BITS-1:0] < CONFIRM_FRAMES_MIN) ?
		CONFIRM_FRAMES_MIN : cfg_wdata[CONFIRM_FRAMES_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_q   <= CONFIRM_FRAMES_RESET;
			duration_q <= CONFIRM_DUR_RESET;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_CONFIRM_FRAMES: begin
					frames_q <= frames_wdata;
				end
				REG_CONFIRM_DURATION: begin
					duration_q <= cfg_wdata[CONFIRM_DUR_BITS-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign confirm_frames      = frames_q;
	assign confirm_duration_us = duration_q;
	// Every register write also starts a new segment.
	assign segment_clear       = cfg_we;

endmodule

FILE: rtl/lhf_decide.sv
module lhf_decide import lhf_pkg::*; #(
	parameter int STAMP_BITS = 48,
	parameter int COUNT_BITS = 16
) (
	input  logic [OPCODE_BITS-1:0]         opcode,
	input  logic [STAMP_BITS-1:0]          stamp_us,
	input  logic                           stamp_finite,
	input  logic [FAULT_BITS-1:0]          fault_flags,
	input  logic                           innovation_reject,
	input  logic                           geometry_bad,
	input  logic                           observability_bad,
	input  logic                           match_converged,
	input  logic                           fitness_high,
	input  logic                           storage_paused,
	input  logic [CONFIRM_FRAMES_BITS-1:0] confirm_frames,
	input  logic [CONFIRM_DUR_BITS-1:0]    confirm_duration_us,
	input  decision_t                      dec_q,
	input  logic [COUNT_BITS-1:0]          run_q,
	input  logic [STAMP_BITS-1:0]          span_q,
	input  logic [STAMP_BITS-1:0]          start_q,
	input  logic                           start_ok_q,
	input  logic [STAMP_BITS-1:0]          last_q,
	output decision_t                      dec_d,
	output logic [COUNT_BITS-1:0]          run_d,
	output logic [STAMP_BITS-1:0]          span_d,
	output logic [STAMP_BITS-1:0]          start_d,
	output logic                           start_ok_d,
	output logic [STAMP_BITS-1:0]          last_d
);
	localparam int CMP_BITS = (COUNT_BITS > CONFIRM_FRAMES_BITS) ?
		COUNT_BITS : CONFIRM_FRAMES_BITS;
	localparam logic [COUNT_BITS-1:0] RUN_MAX = '1;

	logic                  rollback_seen;
	logic                  immediate;
	logic                  indep;
	logic                  hard;
	logic                  confirmed;
	logic                  run_begins;
	logic [STAMP_BITS-1:0] rollback_gap;
	logic [STAMP_BITS-1:0] start_eff;
	logic                  start_ok_eff;
	logic [STAMP_BITS:0]   span_diff;
	logic [STAMP_BITS-1:0] span_new;
	logic [COUNT_BITS-1:0] run_new;
	logic                  frames_ok;
	logic                  duration_ok;
	logic [CONFIRM_DUR_BITS-1:0] duration_min;
	decision_t             ev;

	assign rollback_gap  = last_q - stamp_us;
	assign rollback_seen = (last_q != '0) && stamp_finite && (last_q > stamp_us) &&
		(rollback_gap > STAMP_BITS'(ROLLBACK_US));
	assign immediate     = (fault_flags != '0) || rollback_seen;
	assign indep         = innovation_reject || geometry_bad || observability_bad;
	assign hard          = !match_converged || innovation_reject || (fitness_high && indep);

	// The first frame of a run fixes its start time and whether that time is usable.
	assign run_begins   = (run_q == '0);
	assign start_eff    = run_begins ? stamp_us : start_q;
	assign start_ok_eff = run_begins ? stamp_finite : start_ok_q;
	assign run_new      = (run_q == RUN_MAX) ? run_q : run_q + 1'b1;

	// The borrow bit doubles as the "time went back inside the run" test.
	assign span_diff = {1'b0, stamp_us} - {1'b0, start_eff};
	assign span_new  = (stamp_finite && start_ok_eff && !span_diff[STAMP_BITS]) ?
		span_diff[STAMP_BITS-1:0] : '0;

	assign duration_min = confirm_duration_us - SLACK_US;
	assign frames_ok    = CMP_BITS'(run_new) >= CMP_BITS'(confirm_frames);
	assign duration_ok  = (confirm_duration_us <= SLACK_US) ||
		(span_new >= STAMP_BITS'(duration_min));
	assign confirmed    = hard && frames_ok && duration_ok;

	always_comb begin
		ev = dec_q;
		if (immediate || confirmed) begin
			ev.state   = ST_FAIL_CLOSED;
			ev.latched = 1'b1;
			if (!immediate) begin
				ev.reason = RSN_CONFIRMED;
			end else if (fault_flags[0]) begin
				ev.reason = RSN_NONFINITE;
			end else if (fault_flags[1] || rollback_seen) begin
				ev.reason = RSN_ROLLBACK;
			end else if (fault_flags[2]) begin
				ev.reason = RSN_PHYSICAL;
			end else begin
				ev.reason = RSN_IDENTITY;
			end
		end else if (storage_paused) begin
			ev.state  = ST_PAUSED_IO;
			ev.reason = RSN_IO_NOT_READY;
		end else if (hard || fitness_high || observability_bad || geometry_bad) begin
			ev.state  = ST_PAUSED_QUALITY;
			ev.reason = (fitness_high && !indep) ? RSN_HIGH_FITNESS : RSN_TRANSIENT;
		end else begin
			ev.state  = ST_ACTIVE;
			ev.reason = RSN_HEALTHY;
		end
		ev.writes  = (ev.state == ST_ACTIVE);
		ev.warning = (ev.state != ST_FAIL_CLOSED);
		ev.changed = (ev.state != dec_q.state);
	end

	always_comb begin
		dec_d      = dec_q;
		run_d      = run_q;
		span_d     = span_q;
		start_d    = start_q;
		start_ok_d = start_ok_q;
		last_d     = last_q;
		unique case (opcode_t'(opcode))
			OP_EVIDENCE: begin
				if (dec_q.latched) begin
					// A latched block only reports its held decision.
					dec_d.changed = 1'b0;
				end else begin
					dec_d = ev;
					if (hard) begin
						run_d      = run_new;
						span_d     = span_new;
						start_d    = start_eff;
						start_ok_d = start_ok_eff;
					end else begin
						run_d      = '0;
						span_d     = '0;
						start_d    = '0;
						start_ok_d = 1'b1;
					end
					if (stamp_finite && (stamp_us != '0)) begin
						last_d = stamp_us;
					end
				end
			end
			OP_FAIL_CLOSE: begin
				dec_d.state   = ST_FAIL_CLOSED;
				dec_d.reason  = RSN_EXPLICIT;
				dec_d.writes  = 1'b0;
				dec_d.warning = 1'b0;
				dec_d.latched = 1'b1;
				dec_d.changed = (dec_q.state != ST_FAIL_CLOSED);
			end
			OP_SEGMENT_RESET: begin
				dec_d      = DECISION_RESET;
				run_d      = '0;
				span_d     = '0;
				start_d    = '0;
				start_ok_d = 1'b1;
				last_d     = '0;
			end
			default: begin
				dec_d.changed = 1'b0;
			end
		endcase
	end

endmodule

FILE: rtl/localization_health_failsafe_fsm_unit.sv
// Pipeline: an item is caught in the input register at the edge that accepts it and its
// result is registered as it moves on into the result register, once that is empty or read.
// Throughput: one item per cycle while the output is ready; the state update is a single pass
// of flag logic, compares and subtractions between the input and result registers.
// Reset (arst_n low, asynchronous): both pipeline stages empty, authority active with
// no reason, counters and timestamps zero, confirm_frames 3, confirm_duration_us 0.
`include "assert_macros.svh"

module localization_health_failsafe_fsm_unit import lhf_pkg::*; #(
	parameter int STAMP_BITS = 48,
	parameter int COUNT_BITS = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_wdata,
	lhf_in_if.sink                    in_ch,
	lhf_out_if.source                 out_ch
);
	logic [CONFIRM_FRAMES_BITS-1:0] confirm_frames;
	logic [CONFIRM_DUR_BITS-1:0]    confirm_duration_us;
	logic                           segment_clear;

	// Input register
	logic                   valid_s1;
	logic [OPCODE_BITS-1:0] opcode_s1;
	logic [STAMP_BITS-1:0]  stamp_s1;
	logic                   finite_s1;
	logic [FAULT_BITS-1:0]  faults_s1;
	logic                   innov_s1;
	logic                   geom_s1;
	logic                   obs_s1;
	logic                   conv_s1;
	logic                   fit_s1;
	logic                   io_s1;

	// Block state
	decision_t             dec_q;
	logic [COUNT_BITS-1:0] run_q;
	logic [STAMP_BITS-1:0] span_q;
	logic [STAMP_BITS-1:0] start_q;
	logic                  start_ok_q;
	logic [STAMP_BITS-1:0] last_q;

	decision_t             dec_d;
	logic [COUNT_BITS-1:0] run_d;
	logic [STAMP_BITS-1:0] span_d;
	logic [STAMP_BITS-1:0] start_d;
	logic                  start_ok_d;
	logic [STAMP_BITS-1:0] last_d;

	// Result register
	logic                  valid_s2;
	decision_t             dec_s2;
	logic [COUNT_BITS-1:0] run_s2;
	logic [STAMP_BITS-1:0] span_s2;

	logic advance;
	logic accept;

	lhf_cfg_regs u_cfg (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cfg_we              (cfg_we),
		.cfg_index           (cfg_index),
		.cfg_wdata           (cfg_wdata),
		.confirm_frames      (confirm_frames),
		.confirm_duration_us (confirm_duration_us),
		.segment_clear       (segment_clear)
	);

	lhf_decide #(
		.STAMP_BITS (STAMP_BITS),
		.COUNT_BITS (COUNT_BITS)
	) u_decide (
		.opcode              (opcode_s1),
		.stamp_us            (stamp_s1),
		.stamp_finite        (finite_s1),
		.fault_flags         (faults_s1),
		.innovation_reject   (innov_s1),
		.geometry_bad        (geom_s1),
		.observability_bad   (obs_s1),
		.match_converged     (conv_s1),
		.fitness_high        (fit_s1),
		.storage_paused      (io_s1),
		.confirm_frames      (confirm_frames),
		.confirm_duration_us (confirm_duration_us),
		.dec_q               (dec_q),
		.run_q               (run_q),
		.span_q              (span_q),
		.start_q             (start_q),
		.start_ok_q          (start_ok_q),
		.last_q              (last_q),
		.dec_d               (dec_d),
		.run_d               (run_d),
		.span_d              (span_d),
		.start_d             (start_d),
		.start_ok_d          (start_ok_d),
		.last_d              (last_d)
	);

	// The item in the input register moves on whenever the result register is empty or being read.
	assign advance     = valid_s1 && (!valid_s2 || out_ch.ready);
	assign in_ch.ready = !valid_s1 || advance;
	assign accept      = in_ch.valid && in_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			opcode_s1 <= in_ch.opcode;
			stamp_s1  <= in_ch.stamp_us;
			finite_s1 <= in_ch.stamp_finite;
			faults_s1 <= in_ch.fault_flags;
			innov_s1  <= in_ch.innovation_reject;
			geom_s1   <= in_ch.geometry_bad;
			obs_s1    <= in_ch.observability_bad;
			conv_s1   <= in_ch.match_converged;
			fit_s1    <= in_ch.fitness_high;
			io_s1     <= in_ch.storage_paused;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dec_q      <= DECISION_RESET;
			run_q      <= '0;
			span_q     <= '0;
			start_q    <= '0;
			start_ok_q <= 1'b1;
			last_q     <= '0;
		end else if (segment_clear) begin
			dec_q      <= DECISION_RESET;
			run_q      <= '0;
			span_q     <= '0;
			start_q    <= '0;
			start_ok_q <= 1'b1;
			last_q     <= '0;
		end else if (advance) begin
			dec_q      <= dec_d;
			run_q      <= run_d;
			span_q     <= span_d;
			start_q    <= start_d;
			start_ok_q <= start_ok_d;
			last_q     <= last_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ch.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			dec_s2  <= dec_d;
			run_s2  <= run_d;
			span_s2 <= span_d;
		end
	end

	assign out_ch.valid               = valid_s2;
	assign out_ch.authority_state     = dec_s2.state;
	assign out_ch.reason_code         = dec_s2.reason;
	assign out_ch.writes_allowed      = dec_s2.writes;
	assign out_ch.warning_allowed     = dec_s2.warning;
	assign out_ch.latched             = dec_s2.latched;
	assign out_ch.state_changed       = dec_s2.changed;
	assign out_ch.failure_count       = run_s2;
	assign out_ch.failure_duration_us = span_s2;

	`LHF_ASSERT(a_latch_means_fail_closed, clk, arst_n,
		!valid_s2 || !dec_s2.latched || (dec_s2.state == ST_FAIL_CLOSED))
	`LHF_ASSERT(a_no_run_no_duration, clk, arst_n,
		!valid_s2 || (run_s2 != '0) || (span_s2 == '0))
	`LHF_ASSERT(a_empty_stage_takes_item, clk, arst_n, valid_s1 || in_ch.ready)
	`LHF_ASSERT_NEXT(a_latch_holds, clk, arst_n,
		dec_q.latched && !segment_clear &&
		!(advance && (opcode_s1 == OP_SEGMENT_RESET)),
		dec_q.latched)
	`LHF_ASSERT_NEXT(a_result_follows_advance, clk, arst_n, advance, valid_s2)

endmodule
